FILE: rtl/dfrp_pkg.sv
// Package for the DLE frame receive parser: framing symbols, check codes
// and the result record passed from the decoder core to the top level.
// No dependencies.
package dfrp_pkg;

  localparam logic [7:0] SYM_DLE   = 8'h3D;
  localparam logic [7:0] SYM_START = 8'h53;
  localparam logic [7:0] SYM_END   = 8'h45;

  // Number of payload bytes in a well-formed frame.
  localparam int FRAME_NET = 5;

  // Default frame length limit; the top level hands its parameter down.
  localparam int MAX_FRAME_BYTES_DEF = 14;

  typedef enum logic [1:0] {
    CHK_OK  = 2'd0,
    CHK_LEN = 2'd1,
    CHK_SUM = 2'd2
  } chk_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  cmd;
    logic [7:0]  status;
    logic [15:0] value;
    chk_t        check;
  } result_t;

endpackage

FILE: rtl/dfrp_in_if.sv
// Input channel of the DLE frame receive parser: one received byte per
// transaction. Depends on nothing.
interface dfrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/dfrp_out_if.sv
// Result channel of the DLE frame receive parser: one decoded frame per
// transaction. Depends on nothing.
interface dfrp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_cmd;
  logic [7:0]  reply_status;
  logic [15:0] reply_value;
  logic [1:0]  frame_check;

  modport source (output valid, output reply_cmd, output reply_status,
                  output reply_value, output frame_check, input ready);
  modport sink (input valid, input reply_cmd, input reply_status,
                input reply_value, input frame_check, output ready);
endinterface

FILE: rtl/dfrp_core.sv
// Framing state machine and payload store of the DLE frame receive parser.
// Depends on dfrp_pkg. The result for the presented byte is combinational;
// state moves only when step is high.
module dfrp_core #(
  parameter int MAX_FRAME_BYTES = dfrp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output dfrp_pkg::result_t res
);

  // The count never exceeds MAX_FRAME_BYTES + 1.
  localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME_BYTES);
  localparam logic [CW-1:0] NET_C = CW'(dfrp_pkg::FRAME_NET);

  typedef enum logic {
    ST_HUNT,
    ST_READ
  } state_t;

  state_t        state_r, state_nxt;
  logic          esc_r, esc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    store_r [dfrp_pkg::FRAME_NET];
  logic          take;
  logic [7:0]    take_byte;
  logic [7:0]    sum;
  logic          hit;

  always_comb begin
    state_nxt = state_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    take      = 1'b0;
    take_byte = rx_byte;
    hit       = 1'b0;
    unique case (state_r)
      ST_HUNT: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (rx_byte == dfrp_pkg::SYM_START) begin
            state_nxt = ST_READ;
            cnt_nxt   = '0;
          end
        end else if (rx_byte == dfrp_pkg::SYM_DLE) begin
          esc_nxt = 1'b1;
        end
      end
      ST_READ: begin
        if (cnt_r > MAX_C) begin
          // Runaway frame: drop the byte and hunt again.
          state_nxt = ST_HUNT;
          esc_nxt   = 1'b0;
          cnt_nxt   = '0;
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          if (rx_byte == dfrp_pkg::SYM_DLE) begin
            take = 1'b1;
          end else if (rx_byte == dfrp_pkg::SYM_START) begin
            cnt_nxt = '0;
          end else if (rx_byte == dfrp_pkg::SYM_END) begin
            hit       = 1'b1;
            state_nxt = ST_HUNT;
            cnt_nxt   = '0;
          end
        end else if (rx_byte == dfrp_pkg::SYM_DLE) begin
          esc_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
    if (take) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Trailer check; the store is only read when five bytes were written.
  always_comb begin
    sum        = store_r[0] + store_r[1] + store_r[2] + store_r[3];
    res.hit    = hit;
    res.cmd    = '0;
    res.status = '0;
    res.value  = '0;
    if (cnt_r != NET_C) begin
      res.check = dfrp_pkg::CHK_LEN;
    end else if (sum == store_r[4]) begin
      res.check  = dfrp_pkg::CHK_OK;
      res.cmd    = store_r[0];
      res.status = store_r[1];
      res.value  = {store_r[2], store_r[3]};
    end else begin
      res.check = dfrp_pkg::CHK_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      esc_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Bytes beyond the fifth are counted but not stored.
  always_ff @(posedge clk) begin
    if (step && take && (cnt_r < NET_C)) begin
      store_r[cnt_r[2:0]] <= take_byte;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C + 1'b1)
    else $error("byte count ran past the frame limit");

  a_hunt_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HUNT |-> cnt_r == '0)
    else $error("byte count not cleared while hunting");

  a_hit_on_escape: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> (state_r == ST_READ) && esc_r && (rx_byte == dfrp_pkg::SYM_END))
    else $error("frame result outside an escaped trailer");

endmodule

FILE: rtl/dle_frame_receive_parser_top.sv
// Path: an accepted byte waits in the input register, where the core decodes it;
// a frame result is captured in the result register and offered on out_ch.
// Throughput: one byte per cycle; the input register and the result register
// are both refilled in the cycle they drain, and the input stalls only while
// a result waits at a stalled output.
// Reset (rst_n low, synchronous): both channels empty, framing back to hunting.
module dle_frame_receive_parser_top #(
  parameter int MAX_FRAME_BYTES = dfrp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dfrp_in_if.sink   in_ch,
  dfrp_out_if.source out_ch
);

  logic              stg_valid_r;
  logic [7:0]        stg_byte_r;
  logic              out_valid_r;
  logic [7:0]        cmd_r;
  logic [7:0]        status_r;
  logic [15:0]       value_r;
  logic [1:0]        check_r;
  logic              out_free;
  logic              adv;
  dfrp_pkg::result_t res;

  assign out_free    = !out_valid_r || out_ch.ready;
  // A byte that produces no result can move on even while the output stalls.
  assign adv         = stg_valid_r && (!res.hit || out_free);
  assign in_ch.ready = !stg_valid_r || adv;

  dfrp_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .rx_byte(stg_byte_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stg_valid_r <= 1'b1;
    end else if (adv) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res.hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.hit) begin
      cmd_r    <= res.cmd;
      status_r <= res.status;
      value_r  <= res.value;
      check_r  <= res.check;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.reply_cmd    = cmd_r;
  assign out_ch.reply_status = status_r;
  assign out_ch.reply_value  = value_r;
  assign out_ch.frame_check  = check_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !adv |=> stg_valid_r && $stable(stg_byte_r))
    else $error("stalled input byte lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.hit |-> out_free)
    else $error("result register overwritten before it was taken");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (check_r != dfrp_pkg::CHK_OK) |->
      (cmd_r == '0) && (status_r == '0) && (value_r == '0))
    else $error("error result carries nonzero fields");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for dle_frame_receive_parser_top: drives received bytes,
// predicts every decoded frame in a behavioral decoder and checks each result.
// Depends on dfrp_pkg, dfrp_in_if, dfrp_out_if and the top-level RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = dfrp_pkg::MAX_FRAME_BYTES_DEF;
  localparam int TOTAL_BYTES   = 1400;
  localparam int CALM_FROM     = 1150;
  localparam int HANG_LIMIT    = 400;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct {
    logic [7:0]     cmd;
    logic [7:0]     status;
    logic [15:0]    value;
    dfrp_pkg::chk_t check;
  } frame_reply_t;

  typedef logic [7:0] byte_seq_t[$];

  logic clk;
  logic rst_n;

  dfrp_in_if  in_ch();
  dfrp_out_if out_ch();

  dle_frame_receive_parser_top #(.MAX_FRAME_BYTES(MAX_LEN)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Decoder state mirrored from the block's framing logic.
  bit          in_frame = 1'b0;
  bit          esc_seen = 1'b0;
  int unsigned payload_len = 0;
  logic [7:0]  payload_bytes[dfrp_pkg::FRAME_NET] = '{default: 8'h00};

  frame_reply_t replies_due[$];
  frame_reply_t want_reply;

  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  runaways     = 0;
  int  check_counts[3] = '{0, 0, 0};
  bit  idle_on  = 1'b1;
  bit  stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the decoder by one byte; returns 1 when the byte closes a frame.
  function automatic bit decode_rx_byte(input logic [7:0] b, output frame_reply_t reply);
    logic       take;
    logic [7:0] lit;
    logic [7:0] sum;
    take  = 1'b0;
    lit   = b;
    reply.cmd    = 8'h00;
    reply.status = 8'h00;
    reply.value  = 16'h0000;
    reply.check  = dfrp_pkg::CHK_OK;
    if (!in_frame) begin
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (b == dfrp_pkg::SYM_START) begin
          in_frame    = 1'b1;
          payload_len = 0;
        end
      end else if (b == dfrp_pkg::SYM_DLE) begin
        esc_seen = 1'b1;
      end
      return 1'b0;
    end
    // A frame that ran past the limit is abandoned on the next byte.
    if (payload_len > MAX_LEN) begin
      in_frame    = 1'b0;
      esc_seen    = 1'b0;
      payload_len = 0;
      runaways++;
      return 1'b0;
    end
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == dfrp_pkg::SYM_DLE) begin
        take = 1'b1;
      end else if (b == dfrp_pkg::SYM_START) begin
        payload_len = 0;
      end else if (b == dfrp_pkg::SYM_END) begin
        if (payload_len != dfrp_pkg::FRAME_NET) begin
          reply.check = dfrp_pkg::CHK_LEN;
        end else begin
          sum = payload_bytes[0] + payload_bytes[1] + payload_bytes[2] + payload_bytes[3];
          if (sum == payload_bytes[4]) begin
            reply.cmd    = payload_bytes[0];
            reply.status = payload_bytes[1];
            reply.value  = {payload_bytes[2], payload_bytes[3]};
          end else begin
            reply.check = dfrp_pkg::CHK_SUM;
          end
        end
        in_frame    = 1'b0;
        payload_len = 0;
        return 1'b1;
      end
    end else if (b == dfrp_pkg::SYM_DLE) begin
      esc_seen = 1'b1;
    end else begin
      take = 1'b1;
    end
    if (take) begin
      if (payload_len < dfrp_pkg::FRAME_NET) payload_bytes[payload_len] = lit;
      payload_len++;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one byte and returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] b);
    frame_reply_t reply;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
    if (decode_rx_byte(b, reply)) begin
      replies_due.push_back(reply);
      check_counts[int'(reply.check)]++;
    end
  endtask

  task automatic send_seq(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Start mark after DLE DLE while hunting, a restart that drops a byte,
  // and literal DLE bytes inside a valid frame.
  task automatic test_escaped_frame();
    send_seq({dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_DLE,
              dfrp_pkg::SYM_START, 8'h07, dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_START,
              dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_DLE, 8'hFF, 8'h00,
              dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_DLE, 8'h79,
              dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_END});
  endtask

  // DLE plus an ordinary byte while hunting, an ignored escape inside the
  // frame, and a trailer byte that does not match the sum.
  task automatic test_bad_checksum();
    send_seq({dfrp_pkg::SYM_DLE, 8'h12, dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_START,
              8'h00, 8'h00, 8'h00, dfrp_pkg::SYM_DLE, 8'h12, 8'h00, 8'h01,
              dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_END});
  endtask

  // One-byte frame whose only byte is an unescaped 'E'.
  task automatic test_short_frame();
    send_seq({dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_START, dfrp_pkg::SYM_END,
              dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_END});
  endtask

  task automatic send_random_frame();
    logic [7:0] body[$];
    logic [7:0] specials[5];
    logic [7:0] junk;
    int         n;
    int         roll;
    specials = '{dfrp_pkg::SYM_DLE, dfrp_pkg::SYM_START, dfrp_pkg::SYM_END,
                 8'h00, 8'hFF};
    roll = $urandom_range(0, 9);
    if (roll < 6)      n = dfrp_pkg::FRAME_NET;
    else if (roll < 8) n = $urandom_range(0, 8);
    else               n = $urandom_range(9, MAX_LEN + 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) body.push_back(specials[$urandom_range(0, 4)]);
      else body.push_back(8'($urandom_range(0, 255)));
    end
    if (n == dfrp_pkg::FRAME_NET && $urandom_range(0, 4) != 0)
      body[4] = body[0] + body[1] + body[2] + body[3];
    send_byte(dfrp_pkg::SYM_DLE);
    send_byte(dfrp_pkg::SYM_START);
    foreach (body[i]) begin
      if ($urandom_range(0, 29) == 0) begin
        do junk = 8'($urandom_range(0, 255));
        while (junk == dfrp_pkg::SYM_DLE || junk == dfrp_pkg::SYM_START ||
               junk == dfrp_pkg::SYM_END);
        send_byte(dfrp_pkg::SYM_DLE);
        send_byte(junk);
      end
      if ($urandom_range(0, 59) == 0) begin
        send_byte(dfrp_pkg::SYM_DLE);
        send_byte(dfrp_pkg::SYM_START);
      end
      send_byte(body[i]);
      if (body[i] == dfrp_pkg::SYM_DLE) send_byte(dfrp_pkg::SYM_DLE);
    end
    // Now and then the trailer is lost and the next start mark restarts the frame.
    if ($urandom_range(0, 19) != 0) begin
      send_byte(dfrp_pkg::SYM_DLE);
      send_byte(dfrp_pkg::SYM_END);
    end
  endtask

  task automatic test_random_traffic();
    int gap;
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= CALM_FROM) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          if ($urandom_range(0, 3) == 0) send_byte(dfrp_pkg::SYM_DLE);
          send_byte(8'($urandom_range(0, 255)));
        end
      end
      send_random_frame();
    end
  endtask

  // Output backpressure in random bursts.
  initial begin
    forever begin
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result with nothing expected", {14'h0, out_ch.frame_check}, 16'h0);
      end else begin
        want_reply = replies_due.pop_front();
        if (out_ch.reply_cmd !== want_reply.cmd)
          report_mismatch("reply_cmd", {8'h0, out_ch.reply_cmd}, {8'h0, want_reply.cmd});
        if (out_ch.reply_status !== want_reply.status)
          report_mismatch("reply_status", {8'h0, out_ch.reply_status},
                          {8'h0, want_reply.status});
        if (out_ch.reply_value !== want_reply.value)
          report_mismatch("reply_value", out_ch.reply_value, want_reply.value);
        if (out_ch.frame_check !== want_reply.check)
          report_mismatch("frame_check", {14'h0, out_ch.frame_check},
                          {14'h0, want_reply.check});
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
             HANG_LIMIT, replies_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_escaped_frame();
    test_bad_checksum();
    test_short_frame();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; %0d frames decoded (%0d good, %0d bad length, %0d bad sum)",
             bytes_sent, check_counts[0] + check_counts[1] + check_counts[2],
             check_counts[0], check_counts[1], check_counts[2]);
    $display("%0d oversized frames were dropped; %0d mismatches", runaways, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dfrp_pkg.sv
rtl/dfrp_in_if.sv
rtl/dfrp_out_if.sv
rtl/dfrp_core.sv
rtl/dle_frame_receive_parser_top.sv
tb/testbench.sv
